// ===== sv/uns_pkg.sv =====
// Package with the shared types, codes and name compare function of the name set sorter.
package uns_pkg;

  localparam int unsigned MaxChars = 14;

  typedef logic [MaxChars*8-1:0] name_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_RETURNED = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CMP,
    S_NAME_DONE,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_WR,
    S_ORD_RD,
    S_NAME_RD,
    S_READ_DONE,
    S_RANGE_OUT
  } state_e;

  // Byte-wise unsigned compare of a against b; a proper prefix sorts first.
  function automatic cmp_t name_cmp(name_t a, logic [3:0] la, name_t b, logic [3:0] lb);
    cmp_t       r;
    logic [3:0] n;
    n    = (la < lb) ? la : lb;
    r.eq = (la == lb);
    r.lt = (la < lb);
    for (int i = MaxChars - 1; i >= 0; i--) begin
      if ((4'(i) < n) && (a[i*8 +: 8] != b[i*8 +: 8])) begin
        r.eq = 1'b0;
        r.lt = (a[i*8 +: 8] < b[i*8 +: 8]);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/unique_name_set_sorter.sv =====
// Top level of the unique name set sorter: name collection, duplicate check, sort and read.
// A name character without end mark is stored in the pending name. An ended name is checked
// against the stored names in turn through the single name store read port, stopping at a match.
// A read of a rank out of range returns the range status; otherwise a read first runs a selection sort
// when names were added since the last sort. One item is in work at a time.
// Reset clears the name count, the pending name and the sort flag; the memories are not cleared.
module unique_name_set_sorter #(
  parameter int unsigned MAX_NAMES  = 128,
  parameter int unsigned NAME_CHARS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_name_i,
  input  logic [6:0]  rank_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] name_first8_o,
  output logic [47:0] name_rest_o,
  output logic [3:0]  name_length_o,
  output logic [7:0]  name_total_o,
  output logic        truncated_o
);

  localparam int unsigned IDXW = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_NAMES + 1);
  localparam int unsigned CMPW = (CNTW > 7) ? CNTW : 7;
  localparam int unsigned CHW  = $clog2(NAME_CHARS);
  localparam int unsigned NMW  = NAME_CHARS * 8;
  localparam int unsigned ROWW = NMW + 4;

  uns_pkg::state_e state_q, state_d;

  logic [ROWW-1:0] store_mem [MAX_NAMES];
  logic [IDXW-1:0] order_mem [MAX_NAMES];
  logic [ROWW-1:0] rd_row_q;
  logic [IDXW-1:0] ord_q;

  logic [CNTW-1:0] count_q, count_d;
  logic [NMW-1:0]  pend_q, pend_d;
  logic [3:0]      pend_len_q, pend_len_d;
  logic            ovf_q, ovf_d;
  logic            stale_q, stale_d;
  logic            dup_q, dup_d;
  logic [IDXW-1:0] j_q, j_d;
  logic [IDXW-1:0] pos_q, pos_d;
  logic [6:0]      rank_q, rank_d;
  logic [ROWW-1:0] best_q, best_d;
  logic [IDXW-1:0] best_idx_q, best_idx_d;
  logic            have_q, have_d;
  logic [ROWW-1:0] prev_q, prev_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q, status_d;
  logic [111:0] oname_q, oname_d;
  logic [3:0]  olen_q, olen_d;
  logic [7:0]  ototal_q, ototal_d;
  logic        otrunc_q, otrunc_d;

  logic            accept;
  logic            slot_free;
  logic            st_rd_en;
  logic [IDXW-1:0] st_rd_addr;
  logic            st_wr_en;
  logic            ord_wr_en;
  logic [IDXW-1:0] last_idx;
  logic            not_full;
  uns_pkg::cmp_t   dup_cmp;
  uns_pkg::cmp_t   prev_cmp;
  uns_pkg::cmp_t   best_cmp;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == uns_pkg::S_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign last_idx   = IDXW'(count_q - CNTW'(1));
  assign not_full   = (count_q < CNTW'(MAX_NAMES));

  assign dup_cmp  = uns_pkg::name_cmp(uns_pkg::name_t'(rd_row_q[NMW-1:0]), rd_row_q[ROWW-1:NMW],
                                      uns_pkg::name_t'(pend_q), pend_len_q);
  assign prev_cmp = uns_pkg::name_cmp(uns_pkg::name_t'(prev_q[NMW-1:0]), prev_q[ROWW-1:NMW],
                                      uns_pkg::name_t'(rd_row_q[NMW-1:0]), rd_row_q[ROWW-1:NMW]);
  assign best_cmp = uns_pkg::name_cmp(uns_pkg::name_t'(rd_row_q[NMW-1:0]), rd_row_q[ROWW-1:NMW],
                                      uns_pkg::name_t'(best_q[NMW-1:0]), best_q[ROWW-1:NMW]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      uns_pkg::S_IDLE: begin
        if (accept) begin
          case (uns_pkg::kind_e'(kind_i))
            uns_pkg::KIND_CHAR: begin
              if (end_of_name_i) begin
                state_d = (count_q == '0) ? uns_pkg::S_NAME_DONE : uns_pkg::S_DUP_RD;
              end
            end
            uns_pkg::KIND_READ: begin
              if (CMPW'(rank_i) >= CMPW'(count_q)) begin
                state_d = uns_pkg::S_RANGE_OUT;
              end else if (stale_q) begin
                state_d = uns_pkg::S_SORT_RD;
              end else begin
                state_d = uns_pkg::S_ORD_RD;
              end
            end
            default: state_d = uns_pkg::S_IDLE;
          endcase
        end
      end
      uns_pkg::S_DUP_RD: state_d = uns_pkg::S_DUP_CMP;
      uns_pkg::S_DUP_CMP: begin
        if (dup_cmp.eq || (j_q == last_idx)) begin
          state_d = uns_pkg::S_NAME_DONE;
        end else begin
          state_d = uns_pkg::S_DUP_RD;
        end
      end
      uns_pkg::S_NAME_DONE: begin
        if (slot_free) begin
          state_d = uns_pkg::S_IDLE;
        end
      end
      uns_pkg::S_SORT_RD: state_d = uns_pkg::S_SORT_CMP;
      uns_pkg::S_SORT_CMP: begin
        state_d = (j_q == last_idx) ? uns_pkg::S_SORT_WR : uns_pkg::S_SORT_RD;
      end
      uns_pkg::S_SORT_WR: begin
        state_d = (pos_q == last_idx) ? uns_pkg::S_ORD_RD : uns_pkg::S_SORT_RD;
      end
      uns_pkg::S_ORD_RD:  state_d = uns_pkg::S_NAME_RD;
      uns_pkg::S_NAME_RD: state_d = uns_pkg::S_READ_DONE;
      uns_pkg::S_READ_DONE, uns_pkg::S_RANGE_OUT: begin
        if (slot_free) begin
          state_d = uns_pkg::S_IDLE;
        end
      end
      default: state_d = uns_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    pend_d      = pend_q;
    pend_len_d  = pend_len_q;
    ovf_d       = ovf_q;
    stale_d     = stale_q;
    dup_d       = dup_q;
    j_d         = j_q;
    pos_d       = pos_q;
    rank_d      = rank_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    have_d      = have_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    oname_d     = oname_q;
    olen_d      = olen_q;
    ototal_d    = ototal_q;
    otrunc_d    = otrunc_q;
    st_rd_en    = 1'b0;
    st_rd_addr  = j_q;
    st_wr_en    = 1'b0;
    ord_wr_en   = 1'b0;
    case (state_q)
      uns_pkg::S_IDLE: begin
        if (accept) begin
          j_d    = '0;
          pos_d  = '0;
          dup_d  = 1'b0;
          have_d = 1'b0;
          rank_d = rank_i;
          case (uns_pkg::kind_e'(kind_i))
            uns_pkg::KIND_CHAR: begin
              if (pend_len_q < 4'(NAME_CHARS)) begin
                pend_d[pend_len_q[CHW-1:0]*8 +: 8] = char_byte_i;
                pend_len_d = pend_len_q + 4'd1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            uns_pkg::KIND_CLEAR: begin
              count_d    = '0;
              pend_d     = '0;
              pend_len_d = '0;
              ovf_d      = 1'b0;
              stale_d    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      uns_pkg::S_DUP_RD: st_rd_en = 1'b1;
      uns_pkg::S_DUP_CMP: begin
        dup_d = dup_cmp.eq;
        j_d   = j_q + IDXW'(1);
      end
      uns_pkg::S_NAME_DONE: begin
        if (slot_free) begin
          if (dup_q) begin
            status_d = uns_pkg::ST_DUP;
          end else if (!not_full) begin
            status_d = uns_pkg::ST_FULL;
          end else begin
            status_d = uns_pkg::ST_ADDED;
            st_wr_en = 1'b1;
            count_d  = count_q + CNTW'(1);
            stale_d  = 1'b1;
          end
          out_valid_d = 1'b1;
          oname_d     = 112'(pend_q);
          olen_d      = pend_len_q;
          ototal_d    = (dup_q || !not_full) ? 8'(count_q) : 8'(count_q + CNTW'(1));
          otrunc_d    = ovf_q;
          pend_d      = '0;
          pend_len_d  = '0;
          ovf_d       = 1'b0;
        end
      end
      uns_pkg::S_SORT_RD: st_rd_en = 1'b1;
      uns_pkg::S_SORT_CMP: begin
        if (((pos_q == '0) || prev_cmp.lt) && (!have_q || best_cmp.lt)) begin
          best_d     = rd_row_q;
          best_idx_d = j_q;
          have_d     = 1'b1;
        end
        j_d = j_q + IDXW'(1);
      end
      uns_pkg::S_SORT_WR: begin
        ord_wr_en = 1'b1;
        prev_d    = best_q;
        have_d    = 1'b0;
        j_d       = '0;
        pos_d     = pos_q + IDXW'(1);
        if (pos_q == last_idx) begin
          stale_d = 1'b0;
        end
      end
      uns_pkg::S_NAME_RD: begin
        st_rd_en   = 1'b1;
        st_rd_addr = ord_q;
      end
      uns_pkg::S_READ_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          status_d    = uns_pkg::ST_RETURNED;
          oname_d     = 112'(rd_row_q[NMW-1:0]);
          olen_d      = rd_row_q[ROWW-1:NMW];
          ototal_d    = 8'(count_q);
          otrunc_d    = 1'b0;
        end
      end
      uns_pkg::S_RANGE_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          status_d    = uns_pkg::ST_RANGE;
          oname_d     = '0;
          olen_d      = '0;
          ototal_d    = 8'(count_q);
          otrunc_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_wr_en) begin
      store_mem[count_q[IDXW-1:0]] <= {pend_len_q, pend_q};
    end
    if (st_rd_en) begin
      rd_row_q <= store_mem[st_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ord_wr_en) begin
      order_mem[pos_q] <= best_idx_q;
    end
    if (state_q == uns_pkg::S_ORD_RD) begin
      ord_q <= order_mem[IDXW'(rank_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uns_pkg::S_IDLE;
      count_q     <= '0;
      pend_q      <= '0;
      pend_len_q  <= '0;
      ovf_q       <= 1'b0;
      stale_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      pend_len_q  <= pend_len_d;
      ovf_q       <= ovf_d;
      stale_q     <= stale_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dup_q      <= dup_d;
    j_q        <= j_d;
    pos_q      <= pos_d;
    rank_q     <= rank_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    have_q     <= have_d;
    prev_q     <= prev_d;
    status_q   <= status_d;
    oname_q    <= oname_d;
    olen_q     <= olen_d;
    ototal_q   <= ototal_d;
    otrunc_q   <= otrunc_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign name_first8_o = oname_q[63:0];
  assign name_rest_o   = oname_q[111:64];
  assign name_length_o = olen_q;
  assign name_total_o  = ototal_q;
  assign truncated_o   = otrunc_q;

endmodule

// ===== tb/unique_name_set_sorter_tb.sv =====
// Testbench of the unique name set sorter: directed and random name, read, clear and no-op beats.
`timescale 1ns / 100ps

module unique_name_set_sorter_tb;

  localparam int unsigned NumNames = 128;
  localparam int unsigned NumChars = 14;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] first8;
    logic [47:0] rest;
    logic [3:0]  len;
    logic [7:0]  total;
    logic        trunc;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [7:0]  char_byte_i;
  logic        end_of_name_i;
  logic [6:0]  rank_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [63:0] name_first8_o;
  logic [47:0] name_rest_o;
  logic [3:0]  name_length_o;
  logic [7:0]  name_total_o;
  logic        truncated_o;

  unique_name_set_sorter u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .char_byte_i, .end_of_name_i,
    .rank_i, .out_valid_o, .out_ready_i, .status_o, .name_first8_o, .name_rest_o,
    .name_length_o, .name_total_o, .truncated_o
  );

  // Predictor state.
  logic [7:0]  table_chars [NumNames][NumChars];
  logic [3:0]  table_len [NumNames];
  int unsigned table_count;
  logic [7:0]  cur_chars [NumChars];
  int unsigned cur_len;
  logic        cur_over;

  result_t     expected_results [$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_len;
  int unsigned hold_seq;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("unique_name_set_sorter_tb NOT OK");
    $finish;
  end

  function automatic int compare_names(int unsigned a, logic [7:0] b [NumChars],
                                       int unsigned lb);
    int unsigned n;
    n = (table_len[a] < lb) ? table_len[a] : lb;
    for (int i = 0; i < n; i++)
      if (table_chars[a][i] != b[i]) return (table_chars[a][i] < b[i]) ? -1 : 1;
    if (table_len[a] == lb) return 0;
    return (table_len[a] < lb) ? -1 : 1;
  endfunction

  function automatic result_t pack_name(uns_pkg::status_e st, logic [7:0] s [NumChars],
                                        int unsigned len, logic tr);
    result_t r;
    r = '0;
    for (int i = 0; i < len; i++)
      if (i < 8) r.first8[i*8 +: 8] = s[i];
      else r.rest[(i-8)*8 +: 8] = s[i];
    r.status = st;
    r.len    = len[3:0];
    r.total  = table_count[7:0];
    r.trunc  = tr;
    return r;
  endfunction

  task automatic predict_beat(uns_pkg::kind_e k, logic [7:0] ch, logic eon, logic [6:0] rk);
    bit                dup;
    bit                taken [NumNames];
    int                best;
    uns_pkg::status_e  st;
    logic [7:0]        blank [NumChars];
    if (k == uns_pkg::KIND_CHAR) begin
      if (cur_len < NumChars) begin
        cur_chars[cur_len] = ch;
        cur_len++;
      end else cur_over = 1'b1;
      if (!eon) return;
      dup = 0;
      for (int i = 0; i < table_count; i++)
        if (compare_names(i, cur_chars, cur_len) == 0) dup = 1;
      if (dup) st = uns_pkg::ST_DUP;
      else if (table_count >= NumNames) st = uns_pkg::ST_FULL;
      else begin
        table_chars[table_count] = cur_chars;
        table_len[table_count] = cur_len[3:0];
        table_count++;
        st = uns_pkg::ST_ADDED;
      end
      expected_results.push_back(pack_name(st, cur_chars, cur_len, cur_over));
      foreach (cur_chars[i]) cur_chars[i] = '0;
      cur_len  = 0;
      cur_over = 1'b0;
    end else if (k == uns_pkg::KIND_READ) begin
      foreach (blank[i]) blank[i] = '0;
      if (rk >= table_count) begin
        expected_results.push_back(pack_name(uns_pkg::ST_RANGE, blank, 0, 1'b0));
        return;
      end
      foreach (taken[i]) taken[i] = 0;
      best = 0;
      for (int p = 0; p <= rk; p++) begin
        best = -1;
        for (int j = 0; j < table_count; j++)
          if (!taken[j] && (best < 0 ||
              compare_names(j, table_chars[best], table_len[best]) < 0)) best = j;
        taken[best] = 1;
      end
      expected_results.push_back(pack_name(uns_pkg::ST_RETURNED, table_chars[best],
                                           table_len[best], 1'b0));
    end else if (k == uns_pkg::KIND_CLEAR) begin
      table_count = 0;
      foreach (cur_chars[i]) cur_chars[i] = '0;
      cur_len  = 0;
      cur_over = 1'b0;
    end
  endtask

  task automatic send_beat(uns_pkg::kind_e k, logic [7:0] ch, logic eon, logic [6:0] rk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    char_byte_i   <= ch;
    end_of_name_i <= eon;
    rank_i        <= rk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_beat(k, ch, eon, rk);
  endtask

  task automatic send_name(int unsigned len, int unsigned alpha);
    for (int i = 0; i < len; i++)
      send_beat(uns_pkg::KIND_CHAR,
                (alpha == 0) ? 8'($urandom) : 8'(8'h61 + $urandom_range(alpha - 1)),
                (i == len - 1), 7'($urandom));
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    error_count++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", 64'(status_o), 64'(0));
      end else begin
        want = expected_results.pop_front();
        if (status_o != want.status)
          report_mismatch("status", 64'(status_o), 64'(want.status));
        if (name_first8_o != want.first8)
          report_mismatch("name_first8", name_first8_o, want.first8);
        if (name_rest_o != want.rest)
          report_mismatch("name_rest", 64'(name_rest_o), 64'(want.rest));
        if (name_length_o != want.len)
          report_mismatch("name_length", 64'(name_length_o), 64'(want.len));
        if (name_total_o != want.total)
          report_mismatch("name_total", 64'(name_total_o), 64'(want.total));
        if (truncated_o != want.trunc)
          report_mismatch("truncated", 64'(truncated_o), 64'(want.trunc));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= hold_len;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else out_ready_i <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic test_directed();
    send_beat(uns_pkg::KIND_READ, 8'h00, 1'b0, 7'd0);
    send_beat(uns_pkg::KIND_READ, 8'h00, 1'b0, 7'd127);
    send_beat(uns_pkg::KIND_CHAR, 8'h00, 1'b1, 7'd0);
    send_beat(uns_pkg::KIND_CHAR, 8'hff, 1'b1, 7'd0);
    send_beat(uns_pkg::KIND_CHAR, 8'hff, 1'b0, 7'd0);
    send_beat(uns_pkg::KIND_CHAR, 8'hff, 1'b1, 7'd0);
    send_beat(uns_pkg::KIND_CHAR, 8'h00, 1'b1, 7'd0);
    send_name(14, 0);
    send_name(17, 0);
    send_beat(uns_pkg::KIND_NONE, 8'h55, 1'b1, 7'd1);
    send_beat(uns_pkg::KIND_READ, 8'h00, 1'b0, 7'd0);
    send_beat(uns_pkg::KIND_READ, 8'h00, 1'b0, 7'd4);
    send_beat(uns_pkg::KIND_READ, 8'h00, 1'b0, 7'd6);
    send_beat(uns_pkg::KIND_CHAR, 8'h41, 1'b0, 7'd0);
    send_beat(uns_pkg::KIND_CLEAR, 8'h00, 1'b0, 7'd0);
    send_beat(uns_pkg::KIND_READ, 8'h00, 1'b0, 7'd0);
    wait_drained();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NumNames + 3; i++) begin
      send_beat(uns_pkg::KIND_CHAR, 8'(i), 1'b0, 7'd0);
      send_beat(uns_pkg::KIND_CHAR, 8'(i >> 8), 1'b1, 7'd0);
    end
    send_beat(uns_pkg::KIND_CHAR, 8'd5, 1'b0, 7'd0);
    send_beat(uns_pkg::KIND_CHAR, 8'd0, 1'b1, 7'd0);
    send_beat(uns_pkg::KIND_READ, 8'h00, 1'b0, 7'd127);
    send_beat(uns_pkg::KIND_READ, 8'h00, 1'b0, 7'd0);
    wait_drained();
    send_beat(uns_pkg::KIND_CLEAR, 8'h00, 1'b0, 7'd0);
  endtask

  task automatic test_random(int unsigned beats);
    int unsigned sel;
    for (int n = 0; n < beats; n++) begin
      sel = $urandom_range(99);
      if (sel < 60) send_name($urandom_range(16, 1), $urandom_range(3) == 0 ? 0 : 3);
      else if (sel < 90) send_beat(uns_pkg::KIND_READ, 8'($urandom), 1'($urandom),
                                   7'($urandom_range(table_count + 1)));
      else if (sel < 93) send_beat(uns_pkg::KIND_READ, 8'($urandom), 1'($urandom),
                                   7'($urandom));
      else if (sel < 95) send_beat(uns_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom),
                                   7'($urandom));
      else if (sel < 97) send_beat(uns_pkg::KIND_NONE, 8'($urandom), 1'($urandom),
                                   7'($urandom));
      else send_beat(uns_pkg::KIND_CHAR, 8'($urandom), 1'b0, 7'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_len = 400;
    hold_seq++;
    for (int i = 0; i < 10; i++) send_name(3, 4);
    send_beat(uns_pkg::KIND_READ, 8'h00, 1'b0, 7'd2);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = uns_pkg::KIND_CHAR;
    char_byte_i   = '0;
    end_of_name_i = 1'b0;
    rank_i        = '0;
    error_count   = 0;
    hold_len      = 0;
    hold_seq      = 0;
    table_count   = 0;
    cur_len       = 0;
    cur_over      = 1'b0;
    foreach (cur_chars[i]) cur_chars[i] = '0;
    send_idle_pct = 27;
    recv_idle_pct = 56;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random(16);
    send_idle_pct = 56;
    recv_idle_pct = 27;
    test_backpressure();
    test_random(16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(16);
    wait_drained();
    repeat (40000) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0)
      $display("unique_name_set_sorter_tb OK");
    else
      $display("unique_name_set_sorter_tb NOT OK");
    $finish;
  end

endmodule
